// ===== sv/xcr_pkg.sv =====
// ----------------------------------------------------------------------------
// xcr_pkg
// Shared types and constants for the XMODEM checksum receiver: control
// characters, item classes, receive phases and the result record.
// ----------------------------------------------------------------------------
package xcr_pkg;

  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCan = 8'h18;
  localparam logic [7:0] ComplMask = 8'hFF;

  localparam logic [23:0] NakIntervalReset = 24'd2000000;
  localparam int BlockBytes = 128;

  typedef enum logic [2:0] {
    CLS_TICK,
    CLS_SOH,
    CLS_EOT,
    CLS_CAN,
    CLS_OTHER
  } item_class_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NUMBER,
    PH_COMPL,
    PH_DATA,
    PH_CHECK,
    PH_DONE,
    PH_ABORT,
    PH_OVERFLOW
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUNNING,
    ST_DONE,
    ST_ABORT,
    ST_OVERFLOW
  } status_e;

  typedef struct packed {
    item_class_e cls;
    logic [7:0]  data;
  } xcr_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        store_valid;
    logic [19:0] store_offset;
    logic [7:0]  store_byte;
    status_e     status;
    logic [20:0] received_size;
  } xcr_result_t;

endpackage

// ===== sv/xcr_front.sv =====
// ----------------------------------------------------------------------------
// xcr_front
// Accepts requests, classifies each one as tick or control/data byte and
// holds them in a two-entry queue for the protocol engine.
// ----------------------------------------------------------------------------
module xcr_front import xcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  output logic       item_valid_o,
  output xcr_item_t  item_o,
  input  logic       item_pop_i
);

  xcr_item_t   slot_q [2];
  xcr_item_t   item_in;
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  always_comb begin
    item_in.data = rx_byte_i;
    if (command_i) begin
      item_in.cls = CLS_TICK;
    end else begin
      case (rx_byte_i)
        ChSoh:   item_in.cls = CLS_SOH;
        ChEot:   item_in.cls = CLS_EOT;
        ChCan:   item_in.cls = CLS_CAN;
        default: item_in.cls = CLS_OTHER;
      endcase
    end
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;
  assign count_d      = count_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/xcr_back.sv =====
// ----------------------------------------------------------------------------
// xcr_back
// Protocol engine: walks header, block number, complement, data and
// checksum, keeps the NAK timer, and registers one result per request.
// ----------------------------------------------------------------------------
module xcr_back import xcr_pkg::*; #(
  parameter int BUFFER_BYTES = 1048576
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         item_valid_i,
  input  xcr_item_t    item_i,
  output logic         item_pop_o,
  input  logic         cfg_we_i,
  input  logic [23:0]  cfg_wdata_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output xcr_result_t  result_o
);

  localparam logic [24:0] BufLimit = 25'(BUFFER_BYTES);

  phase_e      phase_q, phase_d;
  logic        started_q, started_d;
  logic [7:0]  exp_blk_q, exp_blk_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [7:0]  rx_num_q, rx_num_d;
  logic [6:0]  idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;
  logic [20:0] acc_q, acc_d;
  logic [23:0] idle_q, idle_d;
  logic [23:0] nak_int_q;
  logic        out_valid_q;
  xcr_result_t res_q, res_d;

  logic        take, active, nak_due, chk_ok, no_room;
  logic [23:0] idle_inc;

  assign take       = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = take;
  assign active     = take && !(phase_q inside {PH_DONE, PH_ABORT, PH_OVERFLOW});
  assign idle_inc   = idle_q + 24'd1;
  assign nak_due    = (idle_inc >= nak_int_q);
  assign chk_ok     = hdr_ok_q && (sum_q == item_i.data);
  assign no_room    = ({4'b0, acc_q} + 25'(BlockBytes)) > BufLimit;

  // next state
  always_comb begin
    phase_d   = phase_q;
    started_d = started_q;
    exp_blk_d = exp_blk_q;
    hdr_ok_d  = hdr_ok_q;
    rx_num_d  = rx_num_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    acc_d     = acc_q;
    idle_d    = idle_q;
    if (active) begin
      if (item_i.cls == CLS_TICK) begin
        if (phase_q == PH_HEADER && !started_q) begin
          idle_d = nak_due ? 24'd0 : idle_inc;
        end
      end else begin
        case (phase_q)
          PH_HEADER: begin
            idle_d = 24'd0;
            case (item_i.cls)
              CLS_EOT: phase_d = PH_DONE;
              CLS_CAN: phase_d = PH_ABORT;
              CLS_SOH: begin
                started_d = 1'b1;
                if (no_room) begin
                  phase_d = PH_OVERFLOW;
                end else begin
                  hdr_ok_d = 1'b1;
                  phase_d  = PH_NUMBER;
                end
              end
              default: if (started_q) phase_d = PH_ABORT;
            endcase
          end
          PH_NUMBER: begin
            rx_num_d = item_i.data;
            hdr_ok_d = (item_i.data == exp_blk_q);
            phase_d  = PH_COMPL;
          end
          PH_COMPL: begin
            if ((rx_num_q ^ item_i.data) != ComplMask) hdr_ok_d = 1'b0;
            idx_d   = 7'd0;
            sum_d   = 8'd0;
            phase_d = PH_DATA;
          end
          PH_DATA: begin
            sum_d = sum_q + item_i.data;
            if (idx_q == 7'(BlockBytes - 1)) begin
              idx_d   = 7'd0;
              phase_d = PH_CHECK;
            end else begin
              idx_d = idx_q + 7'd1;
            end
          end
          PH_CHECK: begin
            if (chk_ok) begin
              exp_blk_d = exp_blk_q + 8'd1;
              acc_d     = acc_q + 21'(BlockBytes);
            end
            phase_d = PH_HEADER;
          end
          default: ;
        endcase
      end
    end
  end

  // result
  always_comb begin
    res_d = '0;
    if (active) begin
      if (item_i.cls == CLS_TICK) begin
        if (phase_q == PH_HEADER && !started_q && nak_due) begin
          res_d.send_valid = 1'b1;
          res_d.send_byte  = ChNak;
        end
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (item_i.cls == CLS_EOT) begin
              res_d.send_valid = 1'b1;
              res_d.send_byte  = ChAck;
            end
          end
          PH_DATA: begin
            if (hdr_ok_q) begin
              res_d.store_valid  = 1'b1;
              res_d.store_offset = 20'(acc_q + {14'b0, idx_q});
              res_d.store_byte   = item_i.data;
            end
          end
          PH_CHECK: begin
            res_d.send_valid = 1'b1;
            res_d.send_byte  = chk_ok ? ChAck : ChNak;
          end
          default: ;
        endcase
      end
    end
    case (phase_d)
      PH_DONE:     res_d.status = ST_DONE;
      PH_ABORT:    res_d.status = ST_ABORT;
      PH_OVERFLOW: res_d.status = ST_OVERFLOW;
      default:     res_d.status = ST_RUNNING;
    endcase
    res_d.received_size = acc_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      started_q   <= 1'b0;
      exp_blk_q   <= 8'd1;
      hdr_ok_q    <= 1'b1;
      rx_num_q    <= 8'd0;
      idx_q       <= 7'd0;
      sum_q       <= 8'd0;
      acc_q       <= 21'd0;
      idle_q      <= 24'd0;
      nak_int_q   <= NakIntervalReset;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      started_q <= started_d;
      exp_blk_q <= exp_blk_d;
      hdr_ok_q  <= hdr_ok_d;
      rx_num_q  <= rx_num_d;
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      acc_q     <= acc_d;
      idle_q    <= idle_d;
      if (cfg_we_i) nak_int_q <= cfg_wdata_i;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// ===== sv/xmodem_checksum_receiver.sv =====
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver
// XMODEM receiver for 128-byte blocks with 8-bit checksum.
// ----------------------------------------------------------------------------
// Each request is one received byte or one idle tick and yields exactly one
// result. The block takes one request per clock cycle while out_ready_i does
// not stall it: a two-entry queue sits in front of the protocol engine, the
// engine handles one request per cycle, and the result leaves through an
// output register, so each request passes a queue slot and then the output
// register. The output register holds while out_ready_i is low; the queue
// keeps accepting until it holds two requests. The NAK interval is written
// through cfg_we_i/cfg_wdata_i and takes effect on the next cycle.
module xmodem_checksum_receiver import xcr_pkg::*; #(
  parameter int BUFFER_BYTES = 1048576
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_valid_o,
  output logic [7:0]  send_byte_o,
  output logic        store_valid_o,
  output logic [19:0] store_offset_o,
  output logic [7:0]  store_byte_o,
  output logic [1:0]  status_o,
  output logic [20:0] received_size_o
);

  xcr_item_t   item;
  logic        item_valid, item_pop;
  xcr_result_t result;

  xcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .rx_byte_i    (rx_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  xcr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign send_valid_o    = result.send_valid;
  assign send_byte_o     = result.send_byte;
  assign store_valid_o   = result.store_valid;
  assign store_offset_o  = result.store_offset;
  assign store_byte_o    = result.store_byte;
  assign status_o        = result.status;
  assign received_size_o = result.received_size;

endmodule

// ===== sv/xcr_checker.sv =====
// ----------------------------------------------------------------------------
// xcr_checker
// Port-level checks for the XMODEM receiver, bound to the top level.
// ----------------------------------------------------------------------------
module xcr_checker import xcr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        send_valid_o,
  input logic [7:0]  send_byte_o,
  input logic        store_valid_o,
  input logic [19:0] store_offset_o,
  input logic [7:0]  store_byte_o,
  input logic [1:0]  status_o,
  input logic [20:0] received_size_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(send_byte_o)
      && $stable(status_o) && $stable(received_size_o))
    else $error("stalled result changed");

  a_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (send_valid_o ? (send_byte_o == ChAck || send_byte_o == ChNak)
                                  : (send_byte_o == 8'd0)))
    else $error("bad reply byte");

  a_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_valid_o |-> status_o == ST_RUNNING && !send_valid_o)
    else $error("store outside running transfer");

  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> received_size_o[6:0] == 7'd0
      && (store_valid_o || (store_offset_o == 20'd0 && store_byte_o == 8'd0)))
    else $error("size or idle store fields wrong");

endmodule

bind xmodem_checksum_receiver xcr_checker u_xcr_checker (.*);

// ===== sim/xmodem_checksum_receiver_test.sv =====
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver_test
// Self-checking testbench for the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
// A scoreboard class carries its own copy of the receiver state and predicts
// one result per accepted request: NAK pacing before the first SOH, header
// and data parsing, checksum ACK/NAK, stored bytes with offsets and the
// status/size outputs. A short directed pass covers the NAK interval settings
// and stray bytes before start. It is followed by randomized blocks, good and
// damaged, with idle ticks mixed in. The run ends with one randomly chosen
// terminal event, then a few requests that must be ignored. Requests come in
// bursts with random gaps, while the result side stalls in changing patterns.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver_test;
  import xcr_pkg::*;

  localparam int BufBytes = 1024;
  localparam int RandomRequests = 1380;
  localparam int StallLimit = 2000;
  localparam int ErrorPrintCap = 50;

  typedef enum int {
    BK_GOOD,
    BK_BAD_SUM,
    BK_BAD_NUM,
    BK_REPEAT,
    BK_BAD_CPL
  } block_kind_e;

  typedef enum int {
    END_EOT,
    END_CAN,
    END_STRAY,
    END_OVERFLOW
  } end_kind_e;

  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_QUARTER,
    RDY_SPARSE
  } stall_mode_e;

  class xmodem_scoreboard;
    phase_e      phase;
    bit          started;
    logic [7:0]  expect_blk;
    bit          hdr_ok;
    logic [7:0]  rcv_num;
    logic [6:0]  idx;
    logic [7:0]  sum;
    logic [20:0] accepted;
    logic [23:0] idle_ticks;
    logic [23:0] interval;
    int          buffer_bytes;
    xcr_result_t awaited_results[$];
    int          errors;
    int          n_checked;
    int          n_ack;
    int          n_nak;
    int          n_store;

    function new(int buf_bytes);
      buffer_bytes = buf_bytes;
      phase = PH_HEADER;
      started = 1'b0;
      expect_blk = 8'd1;
      hdr_ok = 1'b1;
      rcv_num = '0;
      idx = '0;
      sum = '0;
      accepted = '0;
      idle_ticks = '0;
      interval = NakIntervalReset;
      errors = 0;
      n_checked = 0;
      n_ack = 0;
      n_nak = 0;
      n_store = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void note_request(logic cmd, logic [7:0] b);
      xcr_result_t r;
      r = '0;
      if (phase == PH_DONE || phase == PH_ABORT || phase == PH_OVERFLOW) begin
        // finished, everything ignored
      end else if (cmd) begin
        if (phase == PH_HEADER && !started) begin
          idle_ticks = idle_ticks + 24'd1;
          if (idle_ticks >= interval) begin
            idle_ticks = '0;
            r.send_valid = 1'b1;
            r.send_byte = ChNak;
          end
        end
      end else begin
        case (phase)
          PH_HEADER: begin
            idle_ticks = '0;
            if (b == ChEot) begin
              r.send_valid = 1'b1;
              r.send_byte = ChAck;
              phase = PH_DONE;
            end else if (b == ChCan) begin
              phase = PH_ABORT;
            end else if (b == ChSoh) begin
              started = 1'b1;
              if (int'(accepted) + BlockBytes > buffer_bytes) begin
                phase = PH_OVERFLOW;
              end else begin
                hdr_ok = 1'b1;
                phase = PH_NUMBER;
              end
            end else if (started) begin
              phase = PH_ABORT;
            end
          end
          PH_NUMBER: begin
            rcv_num = b;
            hdr_ok = (b == expect_blk);
            phase = PH_COMPL;
          end
          PH_COMPL: begin
            if ((rcv_num ^ b) != ComplMask) hdr_ok = 1'b0;
            idx = '0;
            sum = '0;
            phase = PH_DATA;
          end
          PH_DATA: begin
            if (hdr_ok) begin
              r.store_valid = 1'b1;
              r.store_offset = 20'(accepted + 21'(idx));
              r.store_byte = b;
            end
            sum = sum + b;
            if (idx == 7'(BlockBytes - 1)) begin
              idx = '0;
              phase = PH_CHECK;
            end else begin
              idx = idx + 7'd1;
            end
          end
          default: begin
            r.send_valid = 1'b1;
            if (hdr_ok && sum == b) begin
              expect_blk = expect_blk + 8'd1;
              accepted = accepted + 21'(BlockBytes);
              r.send_byte = ChAck;
            end else begin
              r.send_byte = ChNak;
            end
            phase = PH_HEADER;
          end
        endcase
      end
      case (phase)
        PH_DONE:     r.status = ST_DONE;
        PH_ABORT:    r.status = ST_ABORT;
        PH_OVERFLOW: r.status = ST_OVERFLOW;
        default:     r.status = ST_RUNNING;
      endcase
      r.received_size = accepted;
      if (r.send_valid && r.send_byte == ChAck) n_ack++;
      if (r.send_valid && r.send_byte == ChNak) n_nak++;
      if (r.store_valid) n_store++;
      awaited_results.push_back(r);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= ErrorPrintCap)
          $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    function void check_result(xcr_result_t got);
      xcr_result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= ErrorPrintCap) $error("result with no request outstanding");
        return;
      end
      want = awaited_results.pop_front();
      n_checked++;
      match_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
      match_field("send_byte", 32'(want.send_byte), 32'(got.send_byte));
      match_field("store_valid", 32'(want.store_valid), 32'(got.store_valid));
      match_field("store_offset", 32'(want.store_offset), 32'(got.store_offset));
      match_field("store_byte", 32'(want.store_byte), 32'(got.store_byte));
      match_field("status", 32'(want.status), 32'(got.status));
      match_field("received_size", 32'(want.received_size), 32'(got.received_size));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [23:0] cfg_wdata_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        send_valid_o;
  logic [7:0]  send_byte_o;
  logic        store_valid_o;
  logic [19:0] store_offset_o;
  logic [7:0]  store_byte_o;
  logic [1:0]  status_o;
  logic [20:0] received_size_o;

  xmodem_scoreboard sb;
  int          n_sent = 0;
  int          n_cfg = 0;
  int          burst_left = 0;
  bit          req_up = 1'b0;
  int          quiet_cycles = 0;
  stall_mode_e stall_mode = RDY_ALWAYS;
  int          mode_left = 0;
  logic [1:0]  beat = '0;
  end_kind_e   finish_kind = END_EOT;

  xmodem_checksum_receiver #(
    .BUFFER_BYTES(BufBytes)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .rx_byte_i      (rx_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .send_valid_o   (send_valid_o),
    .send_byte_o    (send_byte_o),
    .store_valid_o  (store_valid_o),
    .store_offset_o (store_offset_o),
    .store_byte_o   (store_byte_o),
    .status_o       (status_o),
    .received_size_o(received_size_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side stall pattern
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    beat <= beat + 2'd1;
    case (stall_mode)
      RDY_ALWAYS:  out_ready_i <= 1'b1;
      RDY_COIN:    out_ready_i <= 1'($urandom_range(0, 1));
      RDY_QUARTER: out_ready_i <= (beat == 2'b00);
      default:     out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin : result_monitor
    xcr_result_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.send_valid = send_valid_o;
      seen.send_byte = send_byte_o;
      seen.store_valid = store_valid_o;
      seen.store_offset = store_offset_o;
      seen.store_byte = store_byte_o;
      seen.status = status_e'(status_o);
      seen.received_size = received_size_o;
      sb.check_result(seen);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drop_request();
    if (req_up) begin
      in_valid_i <= 1'b0;
      req_up = 1'b0;
    end
  endtask

  task automatic send_request(logic cmd, logic [7:0] b);
    if (burst_left == 0) begin
      drop_request();
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    rx_byte_i <= b;
    req_up = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(cmd, b);
    n_sent++;
  endtask

  task automatic tick();
    send_request(1'b1, 8'($urandom));
  endtask

  // idle ticks now and then, even inside a block
  task automatic rx_with_ticks(logic [7:0] b);
    if ($urandom_range(0, 15) == 0) tick();
    send_request(1'b0, b);
  endtask

  task automatic settle();
    drop_request();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_interval(logic [23:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.interval = v;
    n_cfg++;
  endtask

  function automatic logic [7:0] stray_byte();
    logic [7:0] d;
    do d = 8'($urandom); while (d == ChSoh || d == ChEot || d == ChCan);
    return d;
  endfunction

  task automatic send_block(block_kind_e kind);
    logic [7:0] num;
    logic [7:0] cpl;
    logic [7:0] csum;
    logic [7:0] d;
    int         fill;
    num = sb.expect_blk;
    if (kind == BK_BAD_NUM) num = num + 8'($urandom_range(1, 255));
    if (kind == BK_REPEAT) num = num - 8'd1;
    cpl = ~num;
    if (kind == BK_BAD_CPL) cpl = cpl ^ 8'($urandom_range(1, 255));
    fill = $urandom_range(0, 9);
    csum = '0;
    rx_with_ticks(ChSoh);
    rx_with_ticks(num);
    rx_with_ticks(cpl);
    for (int i = 0; i < BlockBytes; i++) begin
      case (fill)
        0: d = 8'h00;
        1: d = 8'hFF;
        2: begin
          case ($urandom_range(0, 2))
            0:       d = ChSoh;
            1:       d = ChEot;
            default: d = ChCan;
          endcase
        end
        default: d = 8'($urandom);
      endcase
      csum = csum + d;
      rx_with_ticks(d);
    end
    if (kind == BK_BAD_SUM) csum = csum ^ 8'($urandom_range(1, 255));
    rx_with_ticks(csum);
  endtask

  initial begin
    block_kind_e kind;
    int          pick;
    sb = new(BufBytes);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset interval, stray byte before start
    tick();
    tick();
    send_request(1'b0, 8'hFF);
    // zero interval: nak on every tick
    write_interval('0);
    tick();
    tick();
    write_interval(24'd1);
    tick();
    tick();
    // stray byte restarts the idle count
    write_interval(24'd3);
    tick();
    tick();
    send_request(1'b0, 8'h00);
    tick();
    tick();
    tick();
    tick();
    write_interval('1);
    tick();
    send_request(1'b0, ChAck);
    tick();

    write_interval(24'($urandom_range(1, 8)));
    repeat ($urandom_range(20, 40)) begin
      if ($urandom_range(0, 3) != 0) tick();
      else send_request(1'b0, stray_byte());
    end

    while (n_sent < RandomRequests && int'(sb.accepted) + BlockBytes <= BufBytes) begin
      pick = $urandom_range(0, 9);
      case (pick)
        6:       kind = BK_BAD_SUM;
        7:       kind = BK_BAD_NUM;
        8:       kind = BK_REPEAT;
        9:       kind = BK_BAD_CPL;
        default: kind = BK_GOOD;
      endcase
      send_block(kind);
      if ($urandom_range(0, 7) == 0) settle();
      if ($urandom_range(0, 19) == 0) write_interval(24'($urandom));
    end

    // hold off until every result is back
    settle();
    finish_kind = end_kind_e'($urandom_range(0, 3));
    case (finish_kind)
      END_EOT:   rx_with_ticks(ChEot);
      END_CAN:   rx_with_ticks(ChCan);
      END_STRAY: rx_with_ticks(stray_byte());
      default: begin
        while (int'(sb.accepted) + BlockBytes <= BufBytes) send_block(BK_GOOD);
        rx_with_ticks(ChSoh);
      end
    endcase
    // status must hold from here on
    send_request(1'b0, ChSoh);
    repeat (7) send_request(1'($urandom_range(0, 1)), 8'($urandom));

    drop_request();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d requests, %0d results checked: %0d ACK, %0d NAK, %0d bytes stored",
             n_sent, sb.n_checked, sb.n_ack, sb.n_nak, sb.n_store);
    $display("%0d interval writes, %0d bytes accepted, transfer ended by %s",
             n_cfg, sb.accepted, finish_kind.name());
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/xcr_pkg.sv
sv/xcr_front.sv
sv/xcr_back.sv
sv/xmodem_checksum_receiver.sv
sv/xcr_checker.sv
sim/xmodem_checksum_receiver_test.sv
